// ===== src/dbra_pkg.sv =====
// ----------------------------------------------------------------------------
// dbra_pkg: shared types and constants
// Widths, register indexes, back-end states and the interface structs
// between the back end, the divider and the top level.
// ----------------------------------------------------------------------------
package dbra_pkg;

   localparam int ACC_W       = 32;
   localparam int SAMPLE_W    = 8;
   localparam int FACTOR_W    = 31;
   localparam int BN_SHIFT    = 3;
   localparam int POOL_ROWS   = 8;
   localparam int POOL_CNT_W  = $clog2(POOL_ROWS);
   localparam int DIV_CNT_W   = $clog2(ACC_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W   = 2;

   localparam logic signed [ACC_W-1:0] CLIP_HIGH = 32'sd127;
   localparam logic signed [ACC_W-1:0] CLIP_LOW  = -32'sd128;

   localparam logic [FACTOR_W-1:0] BN_FACTOR_RESET = 31'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BN_FACTOR    = 2'd0,
      CSR_BN_OFFSET    = 2'd1,
      CSR_REORDER_MODE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROW_DIV,
      BK_ACCUM,
      BK_POOL_SUM,
      BK_POOL_DIV_START,
      BK_POOL_DIV,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] bn_factor;
      logic [ACC_W-1:0]    bn_offset;
      logic                reorder_mode;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [ACC_W-1:0]    dividend;
      logic [FACTOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== src/dbra_if.sv =====
// ----------------------------------------------------------------------------
// dbra channel interfaces
// Request, response and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface dbra_req_if
   import dbra_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] data_sample;
   logic signed [SAMPLE_W-1:0] weight_sample;
   logic                       last_in_row;

   modport source (output valid, output data_sample, output weight_sample,
                   output last_in_row, input ready);
   modport sink   (input valid, input data_sample, input weight_sample,
                   input last_in_row, output ready);
endinterface

interface dbra_rsp_if
   import dbra_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] result_value;
   logic                       div_error;

   modport source (output valid, output result_value, output div_error, input ready);
   modport sink   (input valid, input result_value, input div_error, output ready);
endinterface

interface dbra_csr_if
   import dbra_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ACC_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/int8_dot_bn_relu_avgpool.sv =====
// ----------------------------------------------------------------------------
// int8_dot_bn_relu_avgpool: int8 dot product, batch norm, ReLU, 8-row pool
// Top level: register file, front end, row queue, back end and divider.
// ----------------------------------------------------------------------------
// The front end takes one sample every cycle while the two-entry row queue
// has room, and stalls every sample while the queue is full. The back end
// handles a row in BK_IDLE and BK_ACCUM, adding BK_ROW_DIV in normal mode
// when the batch-norm quotient is computed on the radix-2 divider (one
// quotient bit per cycle, 32 steps). A pool end adds BK_POOL_SUM and BK_EMIT,
// plus BK_POOL_DIV_START and BK_POOL_DIV in reordered mode, where the pooled
// division runs on the same divider. The result waits in an output register while
// new samples keep flowing in. Register writes complete in the cycle they are presented.
module int8_dot_bn_relu_avgpool
   import dbra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dbra_req_if.sink   req_ch,
   dbra_rsp_if.source rsp_ch,
   dbra_csr_if.sink   csr_ch
);

   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [ACC_W-1:0]    offset_ff, offset_in;
   logic                mode_ff, mode_in;
   cfg_type             cfg;

   logic             push_valid;
   logic [ACC_W-1:0] push_data;
   logic             push_ready;
   logic             q_pop;
   logic             q_empty;
   logic [ACC_W-1:0] q_data;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      factor_in = factor_ff;
      offset_in = offset_ff;
      mode_in   = mode_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_BN_FACTOR:    factor_in = csr_ch.data[FACTOR_W-1:0];
            CSR_BN_OFFSET:    offset_in = csr_ch.data;
            CSR_REORDER_MODE: mode_in   = csr_ch.data[0];
            default:          mode_in   = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= BN_FACTOR_RESET;
         offset_ff <= '0;
         mode_ff   <= 1'b0;
      end else begin
         factor_ff <= factor_in;
         offset_ff <= offset_in;
         mode_ff   <= mode_in;
      end
   end

   assign cfg.bn_factor    = factor_ff;
   assign cfg.bn_offset    = offset_ff;
   assign cfg.reorder_mode = mode_ff;

   dbra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   dbra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_data   (q_data)
   );

   dbra_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dbra_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .rsp     (rsp_ch)
   );

endmodule

// ===== src/dbra_front.sv =====
// ----------------------------------------------------------------------------
// dbra_front: sample intake and dot-product accumulation
// Multiplies each accepted sample by its weight and accumulates; a row end
// pushes the finished dot product into the row queue.
// ----------------------------------------------------------------------------
module dbra_front
   import dbra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   dbra_req_if.sink          req,
   output logic              push_valid,
   output logic [ACC_W-1:0]  push_data,
   input  logic              push_ready
);

   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic signed [2*SAMPLE_W-1:0] prod;
   logic [ACC_W-1:0]             sum;
   logic                         accept;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign prod      = req.data_sample * req.weight_sample;
   assign sum       = acc_ff + ACC_W'(prod);

   assign push_valid = accept && req.last_in_row;
   assign push_data  = sum;

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req.last_in_row ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== src/dbra_queue.sv =====
// ----------------------------------------------------------------------------
// dbra_queue: row queue
// Small FIFO of finished dot products between front and back end.
// ----------------------------------------------------------------------------
module dbra_queue
   import dbra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [ACC_W-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             empty,
   output logic [ACC_W-1:0] pop_data
);

   logic [ACC_W-1:0]    mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign empty      = count_ff == '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/dbra_div.sv =====
// ----------------------------------------------------------------------------
// dbra_div: unsigned restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module dbra_div
   import dbra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]     quo_ff, quo_in;
   logic [ACC_W-1:0]     rem_ff, rem_in;
   logic [FACTOR_W-1:0]  dsr_ff, dsr_in;
   logic [ACC_W-1:0]     trial;
   logic [ACC_W-1:0]     diff;
   logic                 ge;

   assign trial = {rem_ff[ACC_W-2:0], quo_ff[ACC_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff : trial;
         quo_in = {quo_ff[ACC_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== src/dbra_back.sv =====
// ----------------------------------------------------------------------------
// dbra_back: batch norm, ReLU and pooling sequencer
// Takes finished dot products from the row queue, rectifies them, sums eight
// rows, normalizing per row or the sum, and emits the clipped pooled value.
// ----------------------------------------------------------------------------
module dbra_back
   import dbra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             q_empty,
   input  logic [ACC_W-1:0] q_data,
   output logic             q_pop,
   output div_req_type      div_req,
   input  div_rsp_type      div_rsp,
   dbra_rsp_if.source       rsp
);

   back_state_type state_ff, state_in;

   logic [ACC_W-1:0]      e_ff, e_in;
   logic [ACC_W-1:0]      pool_ff, pool_in;
   logic [POOL_CNT_W-1:0] count_ff, count_in;
   logic                  err_ff, err_in;
   logic [ACC_W-1:0]      fin_ff, fin_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   result_ff, result_in;
   logic                  div_error_ff, div_error_in;

   logic signed [ACC_W-1:0] off3;
   logic signed [ACC_W-1:0] thr;
   logic [ACC_W-1:0]        e_reo;
   logic [ACC_W-1:0]        num;
   logic                    num_pos;
   logic [FACTOR_W-1:0]     row_div;
   logic                    row_div_zero;
   logic                    factor_zero;
   logic [ACC_W-1:0]        fin_abs;
   logic [SAMPLE_W-1:0]     clipped;
   logic                    slot_free;
   logic                    rsp_load;
   logic                    row_div_start;

   assign off3         = $signed(cfg.bn_offset) >>> BN_SHIFT;
   assign thr          = -off3;
   assign e_reo        = ($signed(q_data) > thr) ? q_data : thr;
   assign num          = q_data + off3;
   assign num_pos      = !num[ACC_W-1] && (num != '0);
   assign row_div      = FACTOR_W'(cfg.bn_factor >> BN_SHIFT);
   assign row_div_zero = row_div == '0;
   assign factor_zero  = cfg.bn_factor == '0;
   assign fin_abs      = fin_ff[ACC_W-1] ? ('0 - fin_ff) : fin_ff;
   assign slot_free    = !rsp_valid_ff || rsp.ready;

   always_comb begin
      if ($signed(fin_ff) > CLIP_HIGH) begin
         clipped = SAMPLE_W'(CLIP_HIGH);
      end else if ($signed(fin_ff) < CLIP_LOW) begin
         clipped = SAMPLE_W'(CLIP_LOW);
      end else begin
         clipped = fin_ff[SAMPLE_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (!cfg.reorder_mode && !row_div_zero && num_pos) begin
                  state_in = BK_ROW_DIV;
               end else begin
                  state_in = BK_ACCUM;
               end
            end
         end
         BK_ROW_DIV: begin
            if (div_rsp.done) begin
               state_in = BK_ACCUM;
            end
         end
         BK_ACCUM: begin
            if (count_ff == POOL_CNT_W'(POOL_ROWS-1)) begin
               state_in = BK_POOL_SUM;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_POOL_SUM: begin
            if (cfg.reorder_mode && !factor_zero) begin
               state_in = BK_POOL_DIV_START;
            end else begin
               state_in = BK_EMIT;
            end
         end
         BK_POOL_DIV_START: begin
            state_in = BK_POOL_DIV;
         end
         BK_POOL_DIV: begin
            if (div_rsp.done) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control strobes
   always_comb begin
      q_pop         = 1'b0;
      row_div_start = 1'b0;
      rsp_load      = 1'b0;
      div_req       = '0;
      case (state_ff)
         BK_IDLE: begin
            q_pop            = !q_empty;
            row_div_start    = !q_empty && !cfg.reorder_mode && !row_div_zero && num_pos;
            div_req.start    = row_div_start;
            div_req.dividend = num;
            div_req.divisor  = row_div;
         end
         BK_POOL_DIV_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = fin_abs;
            div_req.divisor  = cfg.bn_factor;
         end
         BK_EMIT: begin
            rsp_load = slot_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      e_in         = e_ff;
      pool_in      = pool_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      fin_in       = fin_ff;
      neg_in       = neg_ff;
      result_in    = result_ff;
      div_error_in = div_error_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               e_in = '0;
               if (cfg.reorder_mode) begin
                  e_in = e_reo;
               end else if (row_div_zero) begin
                  err_in = 1'b1;
               end
            end
         end
         BK_ROW_DIV: begin
            if (div_rsp.done) begin
               e_in = div_rsp.quotient;
            end
         end
         BK_ACCUM: begin
            pool_in  = pool_ff + e_ff;
            count_in = count_ff + 1'b1;
         end
         BK_POOL_SUM: begin
            if (cfg.reorder_mode) begin
               fin_in = pool_ff + cfg.bn_offset;
               if (factor_zero) begin
                  err_in = 1'b1;
               end
            end else begin
               fin_in = $signed(pool_ff) >>> BN_SHIFT;
            end
         end
         BK_POOL_DIV_START: begin
            neg_in = fin_ff[ACC_W-1];
         end
         BK_POOL_DIV: begin
            if (div_rsp.done) begin
               fin_in = neg_ff ? ('0 - div_rsp.quotient) : div_rsp.quotient;
            end
         end
         BK_EMIT: begin
            if (rsp_load) begin
               result_in    = err_ff ? '0 : clipped;
               div_error_in = err_ff;
               pool_in      = '0;
               err_in       = 1'b0;
            end
         end
         default: begin
            e_in = e_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pool_ff      <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff         <= e_in;
      fin_ff       <= fin_in;
      neg_ff       <= neg_in;
      result_ff    <= result_in;
      div_error_ff <= div_error_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = result_ff;
   assign rsp.div_error    = div_error_ff;

endmodule
